@@ rtl/core/escfr_pkg.sv @@
// Shared types and constants for the escaped frame receiver.
package escfr_pkg;

    // Framing bytes
    localparam logic [7:0] BYTE_SOF     = 8'h7E;
    localparam logic [7:0] BYTE_ESC     = 8'h7D;
    localparam logic [7:0] ESC_XOR_MASK = 8'h20;
    localparam logic [7:0] SUM_INIT     = 8'hFF;

    // Input word kinds (carried on s_tuser)
    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FRAME    = 3'd1;
    localparam logic [2:0] ST_CHECKSUM = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_HELD     = 3'd4;
    localparam logic [2:0] ST_INDEX    = 3'd5;

    // Configuration register indexes
    localparam logic CFG_ESCAPE_ENABLE = 1'b0;
    localparam logic CFG_PAYLOAD_LIMIT = 1'b1;

    // Output buffer depth
    localparam int FIFO_DEPTH = 3;

    // Receive phase, one-hot
    typedef enum logic [7:0] {
        PH_HUNT  = 8'b0000_0001,
        PH_ID    = 8'b0000_0010,
        PH_DEST  = 8'b0000_0100,
        PH_SRC   = 8'b0000_1000,
        PH_SIZE  = 8'b0001_0000,
        PH_DATA  = 8'b0010_0000,
        PH_CHECK = 8'b0100_0000,
        PH_HELD  = 8'b1000_0000
    } phase_t;

    // Result word, status in the lowest bits
    typedef struct packed {
        logic [7:0] read_byte;
        logic [7:0] frame_len;
        logic [7:0] src_addr;
        logic [7:0] dest_addr;
        logic [7:0] frame_id;
        logic       frame_ready;
        logic [2:0] status;
    } result_t;

endpackage

@@ rtl/core/escaped_frame_receiver_core.sv @@
// Escaped frame receiver: deframer, payload memory and output buffer.
//
// Usage:
//   s_ channel: one word per item. s_tuser selects the kind (raw byte,
//   release held frame, read payload byte); s_tdata carries the raw byte
//   and the read index. m_ channel: one result word per input word, with
//   status, held flag, header fields, size and the byte read back.
//   cfg_ port: plain register writes, only while the block is idle.
// Throughput: one word per cycle while s_tready is high. Each word does one
//   read-modify-write of the frame state, one payload memory read and at most one write.
// Path: each accepted word's result and its synchronous memory read are registered
//   in the in-flight stage, then written into the output buffer that drives m_.
// Stall: results queue in a three-word buffer; s_tready drops only when the
//   buffered results plus the word in flight already fill it, so no result is lost.
// Reset: frame state goes to hunting, registers to their defaults, buffer
//   empties. The payload memory is not cleared; only bytes stored by the
//   current frame are ever read back.
module escaped_frame_receiver_core
    import escfr_pkg::*;
#(
    parameter int PAYLOAD_MAX = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [13:8] read_index, [15:14] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [2:0] status, [3] frame_ready, [11:4] frame_id,
                                   // [19:12] dest_addr, [27:20] src_addr,
                                   // [35:28] frame_len, [43:36] read_byte, [47:44] zero
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CNT_W  = $clog2(PAYLOAD_MAX + 1);

    // configuration registers
    logic       escape_enable_reg;
    logic [6:0] payload_limit_reg;

    // frame state
    phase_t             phase_reg, phase_next;
    logic               esc_pending_reg, esc_pending_next;
    logic [7:0]         sum_reg, sum_next;
    logic [CNT_W-1:0]   stored_reg, stored_next;
    logic [7:0]         len_reg, len_next;
    logic [7:0]         id_reg, id_next;
    logic [7:0]         dest_reg, dest_next;
    logic [7:0]         src_reg, src_next;

    // payload memory
    logic [7:0]         payload_mem [PAYLOAD_MAX];
    logic [7:0]         rd_data_reg;
    logic               mem_we;

    // in-flight stage (waiting for memory read data)
    logic               a_valid_reg;
    result_t            a_res_reg;
    logic               a_rd_ok_reg;

    // output buffer
    result_t            fifo_mem [FIFO_DEPTH];
    logic [1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         fifo_cnt_reg;

    logic               s_accept, m_accept;
    logic [1:0]         func;
    logic [7:0]         rx_byte;
    logic [5:0]         read_index;
    logic [7:0]         b_dec;
    logic [7:0]         limit;
    logic [2:0]         status;
    logic               rd_ok;
    result_t            res_now;
    result_t            push_res;

    assign func       = s_tuser;
    assign rx_byte    = s_tdata[7:0];
    assign read_index = s_tdata[13:8];

    assign s_tready = (3'(fifo_cnt_reg) + 3'(a_valid_reg)) < 3'(FIFO_DEPTH);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (fifo_cnt_reg != 2'd0);
    assign m_accept = m_tvalid && m_tready;
    assign m_tdata  = {4'b0000, fifo_mem[rd_ptr_reg]};

    // effective payload limit
    assign limit = (payload_limit_reg > 7'(PAYLOAD_MAX)) ? 8'(PAYLOAD_MAX)
                                                         : {1'b0, payload_limit_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_enable_reg <= 1'b0;
            payload_limit_reg <= 7'd64;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ESCAPE_ENABLE: escape_enable_reg <= cfg_data[0];
                CFG_PAYLOAD_LIMIT: payload_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // next frame state for the incoming word
    always_comb begin
        phase_next       = phase_reg;
        esc_pending_next = esc_pending_reg;
        sum_next         = sum_reg;
        stored_next      = stored_reg;
        len_next         = len_reg;
        id_next          = id_reg;
        dest_next        = dest_reg;
        src_next         = src_reg;
        status           = ST_OK;
        mem_we           = 1'b0;
        rd_ok            = 1'b0;
        b_dec            = (escape_enable_reg && esc_pending_reg) ? (rx_byte ^ ESC_XOR_MASK)
                                                                  : rx_byte;

        case (func)
            FUNC_BYTE: begin
                if (phase_reg == PH_HELD) begin
                    status = ST_HELD;
                end else if (escape_enable_reg && rx_byte == BYTE_ESC) begin
                    if (esc_pending_reg) begin
                        status = ST_FRAME;
                    end else begin
                        esc_pending_next = 1'b1;
                    end
                end else if (escape_enable_reg && rx_byte == BYTE_SOF && phase_reg != PH_HUNT) begin
                    status = ST_FRAME;
                end else begin
                    if (escape_enable_reg) begin
                        esc_pending_next = 1'b0;
                    end
                    case (phase_reg)
                        PH_HUNT: begin
                            if (b_dec != BYTE_SOF) begin
                                status = ST_FRAME;
                            end else begin
                                sum_next   = SUM_INIT;
                                phase_next = PH_ID;
                            end
                        end
                        PH_ID: begin
                            id_next    = b_dec;
                            sum_next   = sum_reg - b_dec;
                            phase_next = PH_DEST;
                        end
                        PH_DEST: begin
                            dest_next  = b_dec;
                            sum_next   = sum_reg - b_dec;
                            phase_next = PH_SRC;
                        end
                        PH_SRC: begin
                            src_next   = b_dec;
                            sum_next   = sum_reg - b_dec;
                            phase_next = PH_SIZE;
                        end
                        PH_SIZE: begin
                            if (b_dec == 8'd0) begin
                                status = ST_FRAME;
                            end else begin
                                stored_next = '0;
                                len_next    = b_dec;
                                sum_next    = sum_reg - b_dec;
                                phase_next  = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            if (8'(stored_reg) >= limit) begin
                                status = ST_OVERFLOW;
                            end else begin
                                mem_we      = 1'b1;
                                stored_next = stored_reg + CNT_W'(1);
                                sum_next    = sum_reg - b_dec;
                                if (8'(stored_next) == len_reg) begin
                                    phase_next = PH_CHECK;
                                end
                            end
                        end
                        PH_CHECK: begin
                            if (b_dec != sum_reg) begin
                                status = ST_CHECKSUM;
                            end else begin
                                phase_next = PH_HELD;
                            end
                        end
                        default: ;
                    endcase
                end
                // any error restarts the frame
                if (status != ST_OK && status != ST_HELD) begin
                    phase_next       = PH_HUNT;
                    esc_pending_next = 1'b0;
                    sum_next         = SUM_INIT;
                    stored_next      = '0;
                    len_next         = 8'd0;
                end
            end
            FUNC_RELEASE: begin
                phase_next       = PH_HUNT;
                esc_pending_next = 1'b0;
                sum_next         = SUM_INIT;
                stored_next      = '0;
                len_next         = 8'd0;
            end
            FUNC_READ: begin
                if (8'(read_index) < 8'(stored_reg) && 8'(read_index) < 8'(PAYLOAD_MAX)) begin
                    rd_ok = 1'b1;
                end else begin
                    status = ST_INDEX;
                end
            end
            default: ;
        endcase
    end

    // result fields known at accept time
    always_comb begin
        res_now.status      = status;
        res_now.frame_ready = (phase_next == PH_HELD);
        res_now.frame_id    = id_next;
        res_now.dest_addr   = dest_next;
        res_now.src_addr    = src_next;
        res_now.frame_len   = len_next;
        res_now.read_byte   = 8'd0;
    end

    // frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            esc_pending_reg <= 1'b0;
            sum_reg         <= SUM_INIT;
            stored_reg      <= '0;
            len_reg         <= 8'd0;
            id_reg          <= 8'd0;
            dest_reg        <= 8'd0;
            src_reg         <= 8'd0;
        end else if (s_accept) begin
            phase_reg       <= phase_next;
            esc_pending_reg <= esc_pending_next;
            sum_reg         <= sum_next;
            stored_reg      <= stored_next;
            len_reg         <= len_next;
            id_reg          <= id_next;
            dest_reg        <= dest_next;
            src_reg         <= src_next;
        end
    end

    // payload memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (s_accept && mem_we) begin
            payload_mem[stored_reg[ADDR_W-1:0]] <= b_dec;
        end
        if (s_accept) begin
            rd_data_reg <= payload_mem[read_index[ADDR_W-1:0]];
        end
    end

    // in-flight stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= s_accept;
        end
        if (s_accept) begin
            a_res_reg   <= res_now;
            a_rd_ok_reg <= rd_ok;
        end
    end

    // merge memory data into the result
    always_comb begin
        push_res           = a_res_reg;
        push_res.read_byte = a_rd_ok_reg ? rd_data_reg : 8'd0;
    end

    // output buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= 2'd0;
            rd_ptr_reg   <= 2'd0;
            fifo_cnt_reg <= 2'd0;
        end else begin
            if (a_valid_reg) begin
                wr_ptr_reg <= (wr_ptr_reg == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
            end
            if (m_accept) begin
                rd_ptr_reg <= (rd_ptr_reg == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + 2'(a_valid_reg) - 2'(m_accept);
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg) begin
            fifo_mem[wr_ptr_reg] <= push_res;
        end
    end

    // checks
    a_no_fifo_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |-> (fifo_cnt_reg < 2'(FIFO_DEPTH) || m_accept))
        else $error("output buffer overflow");

    a_stored_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        8'(stored_reg) <= 8'(PAYLOAD_MAX))
        else $error("payload count beyond memory depth");

    a_data_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (len_reg != 8'd0 && 8'(stored_reg) < len_reg))
        else $error("payload phase with inconsistent length");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the escaped frame receiver core.
`timescale 1ns / 100ps

module testbench;
    import escfr_pkg::*;

    localparam int         PAYLOAD_DEPTH = 64;
    localparam logic [1:0] FUNC_SPARE    = 2'd3;   // unused word kind, must be a no-op
    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         HOLD_CYCLES   = 80;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         MAX_REPORTS   = 10;

    // ways a stimulus frame can be spoiled
    typedef enum int {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_ZERO_SIZE,
        FLAW_OVERFLOW,
        FLAW_STRAY_SOF,
        FLAW_DOUBLE_ESC,
        FLAW_RELEASE
    } frame_flaw_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [7:0] rx_byte, [13:8] read_index, [15:14] zero
    logic [1:0]  s_tuser   = '0;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;          // [2:0] status, [3] frame_ready, [11:4] frame_id,
                                   // [19:12] dest_addr, [27:20] src_addr,
                                   // [35:28] frame_len, [43:36] read_byte
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [6:0]  cfg_data  = '0;

    // traffic shaping
    logic        sender_idle_on = 1'b0;
    logic        rx_stall_on    = 1'b0;
    logic        hold_kick      = 1'b0;
    logic        hold_seen      = 1'b0;
    int          stall_left     = 0;

    result_t     deframer_results_q [$];
    int          bad_results = 0;
    int unsigned words_sent  = 0;

    // receiver state mirror
    logic        esc_on;
    logic [6:0]  limit_reg;
    phase_t      rx_phase;
    logic        esc_armed;
    logic [7:0]  sum_left;
    int unsigned bytes_held;
    logic [7:0]  size_field;
    logic [7:0]  id_field;
    logic [7:0]  dest_field;
    logic [7:0]  src_field;
    logic [7:0]  payload_copy [PAYLOAD_DEPTH];

    escaped_frame_receiver_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- prediction

    // any error or release: back to hunting, header fields kept
    function automatic void drop_frame();
        rx_phase   = PH_HUNT;
        esc_armed  = 1'b0;
        sum_left   = SUM_INIT;
        bytes_held = 0;
        size_field = '0;
    endfunction

    function automatic logic [2:0] absorb_byte(logic [7:0] raw);
        logic [7:0]  b;
        int unsigned lim;
        b   = raw;
        lim = (limit_reg > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : limit_reg;
        if (rx_phase == PH_HELD) return ST_HELD;
        // escape decoding and stray delimiter check
        if (esc_on) begin
            if (b == BYTE_ESC) begin
                if (esc_armed) begin
                    drop_frame();
                    return ST_FRAME;
                end
                esc_armed = 1'b1;
                return ST_OK;
            end
            if (b == BYTE_SOF && rx_phase != PH_HUNT) begin
                drop_frame();
                return ST_FRAME;
            end
            if (esc_armed) begin
                b         = b ^ ESC_XOR_MASK;
                esc_armed = 1'b0;
            end
        end
        case (rx_phase)
            PH_HUNT: begin
                if (b != BYTE_SOF) begin
                    drop_frame();
                    return ST_FRAME;
                end
                sum_left = SUM_INIT;
                rx_phase = PH_ID;
            end
            PH_ID: begin
                id_field = b;
                sum_left = sum_left - b;
                rx_phase = PH_DEST;
            end
            PH_DEST: begin
                dest_field = b;
                sum_left   = sum_left - b;
                rx_phase   = PH_SRC;
            end
            PH_SRC: begin
                src_field = b;
                sum_left  = sum_left - b;
                rx_phase  = PH_SIZE;
            end
            PH_SIZE: begin
                if (b == 8'd0) begin
                    drop_frame();
                    return ST_FRAME;
                end
                bytes_held = 0;
                size_field = b;
                sum_left   = sum_left - b;
                rx_phase   = PH_DATA;
            end
            PH_DATA: begin
                if (bytes_held >= lim) begin
                    drop_frame();
                    return ST_OVERFLOW;
                end
                payload_copy[bytes_held % PAYLOAD_DEPTH] = b;
                bytes_held = bytes_held + 1;
                sum_left   = sum_left - b;
                if (bytes_held == size_field) rx_phase = PH_CHECK;
            end
            default: begin
                if (b != sum_left) begin
                    drop_frame();
                    return ST_CHECKSUM;
                end
                rx_phase = PH_HELD;
            end
        endcase
        return ST_OK;
    endfunction

    function automatic result_t deframe_word(logic [1:0] func, logic [7:0] b, logic [5:0] idx);
        result_t r;
        r        = '0;
        r.status = ST_OK;
        case (func)
            FUNC_BYTE:    r.status = absorb_byte(b);
            FUNC_RELEASE: drop_frame();
            FUNC_READ: begin
                if (idx < bytes_held) r.read_byte = payload_copy[idx];
                else r.status = ST_INDEX;
            end
            default: ;
        endcase
        r.frame_ready = (rx_phase == PH_HELD);
        r.frame_id    = id_field;
        r.dest_addr   = dest_field;
        r.src_addr    = src_field;
        r.frame_len   = size_field;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [7:0] rand_byte();
        // lean toward the framing bytes and their escaped forms
        case ($urandom_range(0, 9))
            0: return BYTE_SOF;
            1: return BYTE_ESC;
            2: return BYTE_SOF ^ ESC_XOR_MASK;
            3: return BYTE_ESC ^ ESC_XOR_MASK;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [5:0] rand_index();
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_idle_on || r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one word, wait for it to be taken, record what it should produce
    task automatic send_word(logic [1:0] func, logic [7:0] b, logic [5:0] idx);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, idx, b};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        deframer_results_q.push_back(deframe_word(func, b, idx));
        words_sent++;
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (deframer_results_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_ESCAPE_ENABLE) esc_on = value[0];
        else limit_reg = value;
    endtask

    // one logical byte on the wire, escaped when needed and now and then when not
    task automatic send_frame_byte(logic [7:0] b);
        logic [7:0] flipped;
        flipped = b ^ ESC_XOR_MASK;
        if (esc_on && (b == BYTE_ESC || b == BYTE_SOF ||
                       (flipped != BYTE_ESC && flipped != BYTE_SOF &&
                        $urandom_range(0, 4) == 0))) begin
            send_word(FUNC_BYTE, BYTE_ESC, rand_index());
            send_word(FUNC_BYTE, flipped, rand_index());
        end else begin
            send_word(FUNC_BYTE, b, rand_index());
        end
    endtask

    task automatic send_frame(int unsigned size_req, frame_flaw_t flaw);
        logic [7:0]  fields [$];
        logic [7:0]  sum;
        int unsigned lim;
        int unsigned n_payload;
        int unsigned cut;
        lim = (limit_reg > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : limit_reg;
        // leftovers of an earlier frame would swallow this one
        if (rx_phase != PH_HUNT || esc_armed)
            send_word(FUNC_RELEASE, rand_byte(), rand_index());
        if (flaw == FLAW_ZERO_SIZE) size_req = 0;
        if (flaw == FLAW_OVERFLOW) size_req = $urandom_range(lim + 1, 255);
        n_payload = (flaw == FLAW_OVERFLOW) ? lim + 1 : size_req;
        fields.push_back(rand_byte());
        fields.push_back(rand_byte());
        fields.push_back(rand_byte());
        fields.push_back(8'(size_req));
        for (int i = 0; i < n_payload; i++) fields.push_back(rand_byte());
        sum = SUM_INIT;
        foreach (fields[i]) sum = sum - fields[i];
        if (flaw == FLAW_NONE || flaw == FLAW_CHECKSUM)
            fields.push_back(flaw == FLAW_CHECKSUM ? sum ^ 8'($urandom_range(1, 255)) : sum);
        cut = fields.size();
        if (flaw inside {FLAW_STRAY_SOF, FLAW_DOUBLE_ESC, FLAW_RELEASE})
            cut = $urandom_range(0, fields.size() - 1);
        // start delimiter, sometimes in escaped form
        if (esc_on && $urandom_range(0, 7) == 0) begin
            send_word(FUNC_BYTE, BYTE_ESC, rand_index());
            send_word(FUNC_BYTE, BYTE_SOF ^ ESC_XOR_MASK, rand_index());
        end else begin
            send_word(FUNC_BYTE, BYTE_SOF, rand_index());
        end
        for (int i = 0; i < cut; i++) send_frame_byte(fields[i]);
        case (flaw)
            FLAW_STRAY_SOF: send_word(FUNC_BYTE, BYTE_SOF, rand_index());
            FLAW_DOUBLE_ESC: begin
                send_word(FUNC_BYTE, BYTE_ESC, rand_index());
                send_word(FUNC_BYTE, BYTE_ESC, rand_index());
            end
            FLAW_RELEASE: send_word(FUNC_RELEASE, rand_byte(), rand_index());
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- tests

    // reset settings: escaping off, full payload limit
    task automatic test_reset_defaults();
        send_word(FUNC_READ, 8'h00, 6'd63);      // nothing stored yet
        send_word(FUNC_SPARE, 8'hFF, 6'd0);
        send_word(FUNC_BYTE, 8'hFF, 6'd63);      // garbage while hunting
        // raw 0x7D and 0x7E are plain data with escaping off
        send_word(FUNC_BYTE, BYTE_SOF, 6'd0);
        send_word(FUNC_BYTE, 8'h00, 6'd0);
        send_word(FUNC_BYTE, 8'hFF, 6'd0);
        send_word(FUNC_BYTE, BYTE_ESC, 6'd0);
        send_word(FUNC_BYTE, 8'h01, 6'd0);
        send_word(FUNC_BYTE, BYTE_SOF, 6'd0);
        send_word(FUNC_BYTE, 8'h04, 6'd0);       // 0xFF - (00+FF+7D+01+7E)
        send_word(FUNC_READ, 8'h00, 6'd0);
        send_word(FUNC_READ, 8'hFF, 6'd1);       // just past the payload
        send_word(FUNC_BYTE, 8'h00, 6'd0);       // refused while held
        send_word(FUNC_RELEASE, 8'h00, 6'd0);
        send_word(FUNC_READ, 8'h00, 6'd0);
    endtask

    task automatic test_escape_cases();
        drain_results();
        write_reg(CFG_ESCAPE_ENABLE, 7'd1);
        write_reg(CFG_PAYLOAD_LIMIT, 7'd2);
        // escaped delimiter while hunting opens a frame
        send_word(FUNC_BYTE, BYTE_ESC, 6'd0);
        send_word(FUNC_BYTE, BYTE_SOF ^ ESC_XOR_MASK, 6'd63);
        // double escape
        send_word(FUNC_BYTE, BYTE_ESC, 6'd0);
        send_word(FUNC_BYTE, BYTE_ESC, 6'd0);
        // stray delimiter inside a frame
        send_word(FUNC_BYTE, BYTE_SOF, 6'd0);
        send_word(FUNC_BYTE, 8'h01, 6'd0);
        send_word(FUNC_BYTE, BYTE_SOF, 6'd0);
        // escape pending in front of a raw delimiter while hunting
        send_word(FUNC_BYTE, BYTE_ESC, 6'd0);
        send_word(FUNC_BYTE, BYTE_SOF, 6'd0);
    endtask

    // one good frame at the payload limit of 2, then each kind of broken one
    task automatic test_frame_flaws();
        send_frame(2, FLAW_NONE);
        send_word(FUNC_READ, 8'h00, 6'd1);
        send_word(FUNC_RELEASE, 8'h00, 6'd0);
        for (int f = FLAW_CHECKSUM; f <= FLAW_RELEASE; f++) send_frame(2, frame_flaw_t'(f));
    endtask

    // receiver parked long enough that the input has to stall
    task automatic test_backpressure();
        drain_results();
        sender_idle_on = 1'b0;
        hold_kick <= ~hold_kick;
        repeat (24) send_word(2'($urandom_range(0, 3)), rand_byte(), rand_index());
        drain_results();
    endtask

    task automatic test_random_traffic(logic esc, logic [6:0] lim, int unsigned n_words);
        int unsigned stop_at;
        int unsigned size_req;
        int unsigned pick;
        int unsigned size_cap;
        drain_results();
        write_reg(CFG_ESCAPE_ENABLE, {6'd0, esc});
        write_reg(CFG_PAYLOAD_LIMIT, lim);
        size_cap = (lim < 8) ? lim : 8;
        stop_at  = words_sent + n_words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            // some stretches run without any idling
            sender_idle_on = ($urandom_range(0, 4) != 0);
            rx_stall_on   <= ($urandom_range(0, 4) != 0);
            if (pick < 65) begin
                size_req = ($urandom_range(0, 4) == 0) ? $urandom_range(1, lim)
                                                       : $urandom_range(1, size_cap);
                send_frame(size_req, FLAW_NONE);
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0)
                        send_word(FUNC_READ, rand_byte(), rand_index());
                    else
                        send_word(FUNC_READ, rand_byte(), 6'($urandom_range(0, size_req - 1)));
                end
                if ($urandom_range(0, 3) == 0) send_word(FUNC_BYTE, rand_byte(), rand_index());
                send_word(FUNC_RELEASE, rand_byte(), rand_index());
            end else if (pick < 85) begin
                send_frame($urandom_range(1, size_cap),
                           frame_flaw_t'($urandom_range(FLAW_CHECKSUM, FLAW_RELEASE)));
            end else if (pick < 97) begin
                repeat ($urandom_range(1, 6))
                    send_word(2'($urandom_range(0, 3)), rand_byte(), rand_index());
            end else begin
                drain_results();
            end
        end
    endtask

    // ---------------------------------------------------------------- result side

    // random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_kick != hold_seen) begin
            hold_seen  <= hold_kick;
            stall_left <= HOLD_CYCLES - 1;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (rx_stall_on && $urandom_range(0, 99) < 20) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[43:0]);
            if (deframer_results_q.size() == 0) begin
                if (bad_results < MAX_REPORTS)
                    $display("unexpected result word %h", m_tdata);
                bad_results++;
            end else begin
                want = deframer_results_q.pop_front();
                if (got !== want) begin
                    if (bad_results < MAX_REPORTS)
                        $display({"mismatch exp/act: st %0d/%0d rdy %0d/%0d id %h/%h ",
                                  "dst %h/%h src %h/%h sz %h/%h rd %h/%h"},
                                 want.status, got.status, want.frame_ready, got.frame_ready,
                                 want.frame_id, got.frame_id, want.dest_addr, got.dest_addr,
                                 want.src_addr, got.src_addr, want.frame_len,
                                 got.frame_len, want.read_byte, got.read_byte);
                    bad_results++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- run

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL escaped_frame_receiver_core");
        $finish;
    end

    initial begin
        esc_on     = 1'b0;
        limit_reg  = 7'd64;
        id_field   = '0;
        dest_field = '0;
        src_field  = '0;
        drop_frame();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_escape_cases();
        sender_idle_on = 1'b1;
        rx_stall_on   <= 1'b1;
        test_frame_flaws();
        test_backpressure();
        test_random_traffic(1'b0, 7'd64, 50);
        test_random_traffic(1'b1, 7'd64, 50);
        test_random_traffic(1'b1, 7'd2, 50);
        test_random_traffic(1'b0, 7'd2, 50);
        test_random_traffic(1'b1, 7'($urandom_range(3, 63)), 50);
        test_random_traffic(1'b0, 7'($urandom_range(3, 63)), 50);

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (bad_results == 0 && deframer_results_q.size() == 0) begin
            $display("PASS escaped_frame_receiver_core");
        end else begin
            $display("FAIL escaped_frame_receiver_core");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/escfr_pkg.sv
rtl/core/escaped_frame_receiver_core.sv
tb/testbench.sv
